/* sv/bex_pkg.sv */
package bex_pkg;

    // Sizes of the mer code space and of a sequence
    localparam int MER_LENGTH = 3;
    localparam int KEY_COUNT  = 64;
    localparam int MAX_LENGTH = 4096;

    // Field widths
    localparam int CODE_W = 7;
    localparam int KEY_W  = 6;
    localparam int FLD_W  = 12;
    localparam int POS_W  = 13;

    // Byte-padded stream widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;
    localparam int M_PAD_W  = M_DATA_W - KEY_W - 2 * FLD_W;

    // Item held in the working stage
    typedef struct packed {
        logic              start;
        logic [CODE_W-1:0] code;
    } stage_t;

    // Outcome of one item: table update, baton and next position
    typedef struct packed {
        logic             wr_en;
        logic             emit;
        logic [FLD_W-1:0] here;
        logic [POS_W-1:0] pos_next;
        logic [KEY_W-1:0] key;
        logic [FLD_W-1:0] begin_res;
        logic [FLD_W-1:0] width;
    } dec_t;

endpackage

/* sv/bex_table.sv */
module bex_table (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [bex_pkg::KEY_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [bex_pkg::KEY_W-1:0] wr_addr,
    input  logic [bex_pkg::FLD_W-1:0] wr_data,
    output logic [bex_pkg::FLD_W-1:0] rd_data
);
    import bex_pkg::*;

    logic [FLD_W-1:0] pos_mem_reg [KEY_COUNT];
    logic [FLD_W-1:0] rd_data_reg;

    // Write the last position; read with forwarding of a same-cycle write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pos_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= pos_mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/bex_eval.sv */
module bex_eval (
    input  bex_pkg::stage_t           stage_i,
    input  logic                      seen_i,
    input  logic [bex_pkg::FLD_W-1:0] last_i,
    input  logic [bex_pkg::POS_W-1:0] pos_i,
    output bex_pkg::dec_t             dec_o
);
    import bex_pkg::*;

    logic [POS_W-1:0] here;
    logic             in_range;
    logic             code_ok;
    logic             hit;
    logic [FLD_W-1:0] distance;
    logic             far;

    // Restart the position count on a start item, saturate at the end
    assign here     = stage_i.start ? '0 : pos_i;
    assign in_range = (here < POS_W'(MAX_LENGTH));
    assign code_ok  = (stage_i.code < CODE_W'(KEY_COUNT));
    assign hit      = seen_i && !stage_i.start;
    assign distance = here[FLD_W-1:0] - last_i;
    assign far      = (distance >= FLD_W'(MER_LENGTH));

    always_comb begin
        dec_o           = '0;
        dec_o.here      = here[FLD_W-1:0];
        dec_o.pos_next  = in_range ? (here + POS_W'(1)) : here;
        dec_o.key       = stage_i.code[KEY_W-1:0];
        dec_o.begin_res = last_i;
        dec_o.width     = distance;
        if (in_range && code_ok) begin
            if (!hit) begin
                // First occurrence: record only
                dec_o.wr_en = 1'b1;
            end else if (far) begin
                dec_o.wr_en = 1'b1;
                dec_o.emit  = 1'b1;
            end
        end
    end

endmodule

/* sv/baton_extractor.sv */
// Baton extractor: pairs repeated k-mer codes in a stream of mer codes.
// Input channel s_*: one mer per item. tdata carries the mer code (code
// KEY_COUNT or above marks an invalid mer, which is skipped but still
// uses up a position); tuser carries the start flag that clears the
// table and restarts the position count at this mer.
// Result channel m_*: one baton item (key, begin, width) for each repeat
// of a code that lies at least MER_LENGTH positions after its recorded
// position; shorter repeats and mers past MAX_LENGTH-1 give nothing.
// A baton is built in the working stage and shown from the output register.
// Throughput: one mer per cycle while the receiver does not stall; the
// position table is read at accept time and written when the mer leaves the
// working stage, with the write forwarded to a same-cycle read of that code.
// Reset clears the seen bits, the position count and both valid flags;
// the position store is left as it is and is only read under a seen bit.
// When the receiver stalls, the baton holds in the output register and
// the working stage holds too, so s_tready falls until m_tready returns.
module baton_extractor (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bex_pkg::S_DATA_W-1:0] s_tdata,  // [6:0] mer_code
    input  logic                         s_tuser,  // [0] start_req
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bex_pkg::M_DATA_W-1:0] m_tdata   // [5:0] key, [17:6] begin_res, [29:18] width
);
    import bex_pkg::*;

    logic                 s_accept;
    logic                 out_free;
    logic                 adv;

    logic                 v1_reg;
    logic                 v1_next;
    stage_t               st_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [KEY_COUNT-1:0] seen_reg;
    logic [KEY_COUNT-1:0] seen_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg;

    logic [FLD_W-1:0]     last_pos;
    logic [KEY_W-1:0]     st_key;
    dec_t                 dec;

    // Handshake: the working stage moves on once the output register is free
    assign out_free = !m_valid_reg || m_tready;
    assign adv      = v1_reg && out_free;
    assign s_tready = !v1_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign st_key   = st_reg.code[KEY_W-1:0];

    // Position store
    bex_table u_table (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (s_tdata[KEY_W-1:0]),
        .wr_en   (adv && dec.wr_en),
        .wr_addr (st_key),
        .wr_data (dec.here),
        .rd_data (last_pos)
    );

    // Decide record, baton or nothing for the working item
    bex_eval u_eval (
        .stage_i (st_reg),
        .seen_i  (seen_reg[st_key]),
        .last_i  (last_pos),
        .pos_i   (pos_reg),
        .dec_o   (dec)
    );

    // Next state of the control registers
    always_comb begin
        v1_next      = v1_reg;
        pos_next     = pos_reg;
        seen_next    = seen_reg;
        m_valid_next = m_valid_reg;
        if (adv) begin
            v1_next      = 1'b0;
            pos_next     = dec.pos_next;
            m_valid_next = dec.emit;
            if (st_reg.start) begin
                seen_next = '0;
            end
            if (dec.wr_en) begin
                seen_next[st_key] = 1'b1;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            v1_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            pos_reg     <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            pos_reg     <= pos_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the item and load the baton
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_reg.start <= s_tuser;
            st_reg.code  <= s_tdata[CODE_W-1:0];
        end
        if (adv && dec.emit) begin
            m_data_reg <= {M_PAD_W'(0), dec.width, dec.begin_res, dec.key};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // A baton always spans at least one mer length
    a_width_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:18] >= FLD_W'(MER_LENGTH)))
        else $error("baton narrower than a mer");

    // Both ends of a baton lie inside the sequence
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (({1'b0, m_tdata[17:6]} + {1'b0, m_tdata[29:18]})
                      < POS_W'(MAX_LENGTH)))
        else $error("baton end past the sequence");

    // The position count never passes its saturation value
    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_LENGTH))
        else $error("position count overran");

    // A start item leaves only its own code marked as seen
    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && st_reg.start) |=> ($countones(seen_reg) <= 1))
        else $error("seen bits not cleared on start");
`endif

endmodule
